// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define FSIG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define FSIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fsig_pkg.sv =====
`timescale 1ns / 1ps

package fsig_pkg;

  // Register stages of one fused multiply-add.
  localparam int FMA_LAT = 5;
  // Register stages of the reciprocal estimate: four divide stages and a pack stage.
  localparam int RCP_LAT = 5;

  // Signed exponent width used inside the arithmetic.
  localparam int EXP_W = 12;
  typedef logic signed [EXP_W-1:0] exp_t;

  // Single-precision constants.
  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_MAGIC     = 32'h4B40_007F;
  localparam logic [31:0] F_MAGIC_NEG = 32'hCB40_007F;
  localparam logic [31:0] F_LOG2E     = 32'h3FB8_AA3B;
  localparam logic [31:0] F_MLN2      = 32'hBF31_7218;
  localparam logic [31:0] F_C1        = 32'h3F7F_FFFB;
  localparam logic [31:0] F_C2        = 32'h3EFF_FEE3;
  localparam logic [31:0] F_C3        = 32'h3E2A_AD40;
  localparam logic [31:0] F_C4        = 32'h3D2B_9D0D;
  localparam logic [31:0] F_C5        = 32'h3C07_CFCE;
  localparam logic [31:0] F_NEG_ZERO  = 32'h8000_0000;
  localparam logic [31:0] F_SIGN      = 32'h8000_0000;
  localparam logic [31:0] F_NAN_SET   = 32'h8040_0000;
  localparam logic [30:0] CUTOFF_ABS  = 31'h42AE_AC4F;
  localparam logic [30:0] INF_ABS     = 31'h7F80_0000;

  // Input word.
  typedef struct packed {
    logic [31:0] x_bits;
    logic        end_of_vector;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [31:0] y_bits;
    logic        end_of_vector_out;
  } out_word_t;

  // Leading-zero count of a 63-bit word; an all-zero word gives 63.
  function automatic logic [5:0] lzc63(input logic [62:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd63;
    found = 1'b0;
    for (int i = 62; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(62 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/fsig_fma.sv =====
`timescale 1ns / 1ps

// Fused multiply-add a*b + c with one round-to-nearest-even step.
// Five register stages: multiply, normalize and order, align and add,
// normalize the sum, round and pack.
module fsig_fma (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] r
);

  // Stage 1: unpack, multiply, normalize the addend.
  logic [23:0]         ma, mb, mc;
  fsig_pkg::exp_t      ea, eb, ec;
  logic [5:0]          lzc_c;
  logic [47:0]         s1_mp_nxt;
  fsig_pkg::exp_t      s1_ep_nxt, s1_ec_nxt;
  logic [61:0]         s1_mc_nxt;

  logic [47:0]         s1_mp_r;
  fsig_pkg::exp_t      s1_ep_r, s1_ec_r;
  logic [61:0]         s1_mc_r;
  logic                s1_sp_r, s1_sc_r, s1_pz_r, s1_cz_r;

  always_comb begin
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    mc = {|c[30:23], c[22:0]};
    ea = (a[30:23] == 8'd0) ? fsig_pkg::exp_t'(-149)
                            : fsig_pkg::exp_t'(a[30:23]) - fsig_pkg::exp_t'(150);
    eb = (b[30:23] == 8'd0) ? fsig_pkg::exp_t'(-149)
                            : fsig_pkg::exp_t'(b[30:23]) - fsig_pkg::exp_t'(150);
    ec = (c[30:23] == 8'd0) ? fsig_pkg::exp_t'(-149)
                            : fsig_pkg::exp_t'(c[30:23]) - fsig_pkg::exp_t'(150);
    s1_mp_nxt = 48'(ma) * 48'(mb);
    s1_ep_nxt = ea + eb;
    lzc_c     = fsig_pkg::lzc63({mc, 39'd0});
    s1_mc_nxt = 62'(mc) << (6'd38 + lzc_c);
    s1_ec_nxt = ec - fsig_pkg::exp_t'(38) - fsig_pkg::exp_t'(lzc_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mp_r <= s1_mp_nxt;
      s1_ep_r <= s1_ep_nxt;
      s1_sp_r <= a[31] ^ b[31];
      s1_mc_r <= s1_mc_nxt;
      s1_ec_r <= s1_ec_nxt;
      s1_sc_r <= c[31];
      s1_pz_r <= (ma == 24'd0) || (mb == 24'd0);
      s1_cz_r <= (mc == 24'd0);
    end
  end

  // Stage 2: normalize the product and order the two terms by magnitude.
  logic [5:0]          lzc_p;
  logic [61:0]         mp_n;
  fsig_pkg::exp_t      ep_n;
  logic                prod_big;
  logic [61:0]         s2_big_nxt, s2_sml_nxt;
  fsig_pkg::exp_t      s2_ebig_nxt, s2_esml;
  logic                s2_sbig_nxt, s2_ssml_nxt;

  logic [61:0]         s2_big_r, s2_sml_r;
  fsig_pkg::exp_t      s2_ebig_r, s2_dd_r;
  logic                s2_sbig_r, s2_ssml_r, s2_sz_r, s2_bz_r, s2_zs_r;

  always_comb begin
    lzc_p    = fsig_pkg::lzc63({s1_mp_r, 15'd0});
    mp_n     = 62'(s1_mp_r) << (6'd14 + lzc_p);
    ep_n     = s1_ep_r - fsig_pkg::exp_t'(14) - fsig_pkg::exp_t'(lzc_p);
    prod_big = (ep_n > s1_ec_r) || ((ep_n == s1_ec_r) && (mp_n >= s1_mc_r));
    if (s1_cz_r || (!s1_pz_r && prod_big)) begin
      s2_big_nxt  = mp_n;
      s2_ebig_nxt = ep_n;
      s2_sbig_nxt = s1_sp_r;
      s2_sml_nxt  = s1_mc_r;
      s2_esml     = s1_ec_r;
      s2_ssml_nxt = s1_sc_r;
    end else begin
      s2_big_nxt  = s1_mc_r;
      s2_ebig_nxt = s1_ec_r;
      s2_sbig_nxt = s1_sc_r;
      s2_sml_nxt  = mp_n;
      s2_esml     = ep_n;
      s2_ssml_nxt = s1_sp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_big_r  <= s2_big_nxt;
      s2_sml_r  <= s2_sml_nxt;
      s2_ebig_r <= s2_ebig_nxt;
      s2_dd_r   <= s2_ebig_nxt - s2_esml;
      s2_sbig_r <= s2_sbig_nxt;
      s2_ssml_r <= s2_ssml_nxt;
      s2_sz_r   <= s1_pz_r | s1_cz_r;
      s2_bz_r   <= s1_pz_r & s1_cz_r;
      s2_zs_r   <= s1_sp_r & s1_sc_r;
    end
  end

  // Stage 3: align the smaller term with a sticky bit, then add or subtract.
  logic [61:0]         sml_al;
  logic [62:0]         s3_sum_nxt;

  logic [62:0]         s3_sum_r;
  fsig_pkg::exp_t      s3_ebig_r;
  logic                s3_sbig_r, s3_bz_r, s3_zs_r;

  always_comb begin
    if (s2_sz_r) begin
      sml_al = 62'd0;
    end else if (s2_dd_r >= fsig_pkg::exp_t'(63)) begin
      sml_al = 62'd1;
    end else begin
      sml_al = (s2_sml_r >> s2_dd_r[5:0])
             | 62'(|(s2_sml_r & ~({62{1'b1}} << s2_dd_r[5:0])));
    end
    if (s2_sbig_r == s2_ssml_r) begin
      s3_sum_nxt = {1'b0, s2_big_r} + {1'b0, sml_al};
    end else begin
      s3_sum_nxt = {1'b0, s2_big_r} - {1'b0, sml_al};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= s3_sum_nxt;
      s3_ebig_r <= s2_ebig_r;
      s3_sbig_r <= s2_sbig_r;
      s3_bz_r   <= s2_bz_r;
      s3_zs_r   <= s2_zs_r;
    end
  end

  // Stage 4: bring the leading one of the sum to the top bit.
  logic [5:0]          lzc_s;

  logic [62:0]         s4_nrm_r;
  fsig_pkg::exp_t      s4_be_r;
  logic                s4_sbig_r, s4_bz_r, s4_zs_r, s4_mz_r;

  always_comb begin
    lzc_s = fsig_pkg::lzc63(s3_sum_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nrm_r  <= s3_sum_r << lzc_s;
      s4_be_r   <= s3_ebig_r + fsig_pkg::exp_t'(189) - fsig_pkg::exp_t'(lzc_s);
      s4_sbig_r <= s3_sbig_r;
      s4_bz_r   <= s3_bz_r;
      s4_zs_r   <= s3_zs_r;
      s4_mz_r   <= (s3_sum_r == 63'd0);
    end
  end

  // Stage 5: denormalize if needed, round to nearest even and pack.
  fsig_pkg::exp_t      den_amt;
  logic [5:0]          amt;
  logic [62:0]         shn;
  logic                lost, g_bit, st_bit;
  logic [23:0]         q;
  logic [24:0]         qr;
  logic [7:0]          base;
  logic [31:0]         mag;
  logic [31:0]         r_nxt;
  logic [31:0]         r_r;

  always_comb begin
    den_amt = fsig_pkg::exp_t'(1) - s4_be_r;
    if (s4_be_r >= fsig_pkg::exp_t'(1)) begin
      amt  = 6'd0;
      base = s4_be_r[7:0] - 8'd1;
    end else begin
      amt  = (den_amt >= fsig_pkg::exp_t'(63)) ? 6'd63 : den_amt[5:0];
      base = 8'd0;
    end
    shn    = s4_nrm_r >> amt;
    lost   = |(s4_nrm_r & ~({63{1'b1}} << amt));
    q      = shn[62:39];
    g_bit  = shn[38];
    st_bit = (|shn[37:0]) | lost;
    qr     = {1'b0, q} + 25'(g_bit & (st_bit | q[0]));
    mag    = {1'b0, base, 23'd0} + 32'(qr);
    if ((s4_be_r >= fsig_pkg::exp_t'(255)) || (mag >= {1'b0, fsig_pkg::INF_ABS})) begin
      mag = {1'b0, fsig_pkg::INF_ABS};
    end
    if (s4_bz_r) begin
      r_nxt = {s4_zs_r, 31'd0};
    end else if (s4_mz_r) begin
      r_nxt = 32'd0;
    end else begin
      r_nxt = {s4_sbig_r, mag[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
    end
  end

  assign r = r_r;

endmodule

// ===== src/fp32_sigmoid_unit.sv =====
`timescale 1ns / 1ps
// The depth from the edge that accepts a word to out_valid is set by
// thirteen chained 5-stage multiply-add units and the 5-stage reciprocal estimate.
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Reset clears the valid bits of every stage and the output register; data
// registers are not reset.

`include "assert_macros.svh"

module fp32_sigmoid_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsig_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fsig_pkg::out_word_t out_data
);

  localparam int L    = fsig_pkg::FMA_LAT;
  localparam int RL   = fsig_pkg::RCP_LAT;
  // Times at which each result appears, counted in stages from the input register.
  localparam int T_VN = L;
  localparam int T_T  = 3 * L;
  localparam int T_TS = 4 * L;
  localparam int T_P1 = 7 * L;
  localparam int T_E  = 8 * L;
  localparam int T_D  = 9 * L;
  localparam int T_R0 = 9 * L + RL;
  localparam int T_G  = 10 * L + RL;
  localparam int T_F  = 12 * L + RL;
  localparam int T_Y  = 13 * L + RL;
  // Lengths of the side delay lines.
  localparam int S_LEN  = T_P1 - T_VN;
  localparam int T_LEN  = 3 * L;
  localparam int TS_LEN = T_P1 - T_TS;
  localparam int E_LEN  = T_F - L - T_E;
  localparam int D_LEN  = RL;
  localparam int R0_LEN = L;
  localparam int F_LEN  = L;
  // Reciprocal divider: quotient bits, divide stages, bits per stage.
  localparam int RC_QW = 15;
  localparam int RC_ST = RL - 1;
  localparam int RC_BS = 4;

  // The pipeline moves when the output register is free or being taken.
  logic adv;
  logic out_valid_r;
  fsig_pkg::out_word_t out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Input words and valid bits travel down the full depth.
  fsig_pkg::in_word_t in_pipe_r [T_Y+1];
  logic [T_Y:0]       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[T_Y-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_pipe_r[0] <= in_data;
      for (int i = 1; i <= T_Y; i++) begin
        in_pipe_r[i] <= in_pipe_r[i-1];
      end
    end
  end

  // Multiply-add results.
  logic [31:0] vn, nn, tt, p4, ts, p3, p2, p1, ee, dv, gg, rr, ff, y1;
  logic [31:0] r0_r;
  logic [31:0] z_in, z_red, f_cut;

  // Side delay lines.
  logic [31:0] s_d_r  [S_LEN];
  logic [31:0] t_d_r  [T_LEN];
  logic [31:0] ts_d_r [TS_LEN];
  logic [31:0] e_d_r  [E_LEN];
  logic [31:0] d_d_r  [D_LEN];
  logic [31:0] r0_d_r [R0_LEN];
  logic [31:0] f_d_r  [F_LEN];

  always_ff @(posedge clk) begin
    if (adv) begin
      s_d_r[0]  <= {vn[8:0], 23'd0};
      t_d_r[0]  <= tt;
      ts_d_r[0] <= ts;
      e_d_r[0]  <= ee;
      d_d_r[0]  <= dv;
      r0_d_r[0] <= r0_r;
      f_d_r[0]  <= f_cut;
      for (int i = 1; i < S_LEN; i++)  s_d_r[i]  <= s_d_r[i-1];
      for (int i = 1; i < T_LEN; i++)  t_d_r[i]  <= t_d_r[i-1];
      for (int i = 1; i < TS_LEN; i++) ts_d_r[i] <= ts_d_r[i-1];
      for (int i = 1; i < E_LEN; i++)  e_d_r[i]  <= e_d_r[i-1];
      for (int i = 1; i < D_LEN; i++)  d_d_r[i]  <= d_d_r[i-1];
      for (int i = 1; i < R0_LEN; i++) r0_d_r[i] <= r0_d_r[i-1];
      for (int i = 1; i < F_LEN; i++)  f_d_r[i]  <= f_d_r[i-1];
    end
  end

  // z = -|x| at the two places it is used.
  assign z_in  = {1'b1, in_pipe_r[0].x_bits[30:0]};
  assign z_red = {1'b1, in_pipe_r[2*L].x_bits[30:0]};

  // Range reduction: n from a magic-bias rounding, then t = z - n*ln2.
  fsig_fma u_vn (.clk(clk), .en(adv), .a(z_in), .b(fsig_pkg::F_LOG2E),
                 .c(fsig_pkg::F_MAGIC), .r(vn));
  fsig_fma u_nn (.clk(clk), .en(adv), .a(vn), .b(fsig_pkg::F_ONE),
                 .c(fsig_pkg::F_MAGIC_NEG), .r(nn));
  fsig_fma u_t  (.clk(clk), .en(adv), .a(nn), .b(fsig_pkg::F_MLN2), .c(z_red), .r(tt));

  // Horner polynomial, with t*s computed alongside the first step.
  fsig_fma u_p4 (.clk(clk), .en(adv), .a(fsig_pkg::F_C5), .b(tt), .c(fsig_pkg::F_C4),
                 .r(p4));
  fsig_fma u_ts (.clk(clk), .en(adv), .a(tt), .b(s_d_r[T_T-T_VN-1]),
                 .c(fsig_pkg::F_NEG_ZERO), .r(ts));
  fsig_fma u_p3 (.clk(clk), .en(adv), .a(p4), .b(t_d_r[L-1]), .c(fsig_pkg::F_C3), .r(p3));
  fsig_fma u_p2 (.clk(clk), .en(adv), .a(p3), .b(t_d_r[2*L-1]), .c(fsig_pkg::F_C2),
                 .r(p2));
  fsig_fma u_p1 (.clk(clk), .en(adv), .a(p2), .b(t_d_r[3*L-1]), .c(fsig_pkg::F_C1),
                 .r(p1));

  // exp(z) = s + (t*s)*p, then d = 1 + exp(z).
  fsig_fma u_e  (.clk(clk), .en(adv), .a(ts_d_r[TS_LEN-1]), .b(p1), .c(s_d_r[S_LEN-1]),
                 .r(ee));
  fsig_fma u_d  (.clk(clk), .en(adv), .a(ee), .b(fsig_pkg::F_ONE), .c(fsig_pkg::F_ONE),
                 .r(dv));

  // Reciprocal estimate: round(2^37 / md) by restoring division, four bits a stage.
  logic [23:0] rc_md;
  logic [24:0] rc_rem_in [RC_ST];
  logic [RC_QW-1:0] rc_q_in [RC_ST];
  logic [23:0] rc_md_in [RC_ST];
  logic [7:0]  rc_ex_in [RC_ST];
  logic        rc_sg_in [RC_ST];
  logic [24:0] rc_rem_nxt [RC_ST];
  logic [RC_QW-1:0] rc_q_nxt [RC_ST];
  logic [24:0] rc_rem_r [RC_ST];
  logic [RC_QW-1:0] rc_q_r [RC_ST];
  logic [23:0] rc_md_r [RC_ST];
  logic [7:0]  rc_ex_r [RC_ST];
  logic        rc_sg_r [RC_ST];

  assign rc_md = {1'b1, dv[22:0]};

  always_comb begin
    rc_rem_in[0] = 25'(24'h80_0000 + 24'(rc_md[23:15]));
    rc_q_in[0]   = '0;
    rc_md_in[0]  = rc_md;
    rc_ex_in[0]  = dv[30:23];
    rc_sg_in[0]  = dv[31];
    for (int j = 1; j < RC_ST; j++) begin
      rc_rem_in[j] = rc_rem_r[j-1];
      rc_q_in[j]   = rc_q_r[j-1];
      rc_md_in[j]  = rc_md_r[j-1];
      rc_ex_in[j]  = rc_ex_r[j-1];
      rc_sg_in[j]  = rc_sg_r[j-1];
    end
  end

  always_comb begin
    logic [25:0]       tr;
    logic [24:0]       rem_v;
    logic [RC_QW-1:0]  q_v;
    int                bi;
    for (int j = 0; j < RC_ST; j++) begin
      rem_v = rc_rem_in[j];
      q_v   = rc_q_in[j];
      for (int k = 0; k < RC_BS; k++) begin
        bi = RC_QW - 1 - RC_BS * j - k;
        if (bi >= 0) begin
          tr = {rem_v, rc_md_in[j][bi]};
          if (tr >= {1'b0, rc_md_in[j], 1'b0}) begin
            tr     = tr - {1'b0, rc_md_in[j], 1'b0};
            q_v[bi] = 1'b1;
          end
          rem_v = tr[24:0];
        end
      end
      rc_rem_nxt[j] = rem_v;
      rc_q_nxt[j]   = q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < RC_ST; j++) begin
        rc_rem_r[j] <= rc_rem_nxt[j];
        rc_q_r[j]   <= rc_q_nxt[j];
        rc_md_r[j]  <= rc_md_in[j];
        rc_ex_r[j]  <= rc_ex_in[j];
        rc_sg_r[j]  <= rc_sg_in[j];
      end
    end
  end

  // Pack the quotient as a float; it is exact, so no rounding is needed.
  logic [5:0]  rc_lz;
  logic [23:0] rc_mant;

  always_comb begin
    rc_lz   = fsig_pkg::lzc63({rc_q_r[RC_ST-1], 48'd0});
    rc_mant = 24'(rc_q_r[RC_ST-1]) << (6'd9 + rc_lz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r <= {rc_sg_r[RC_ST-1], 8'd254 - 8'(rc_lz) - rc_ex_r[RC_ST-1], rc_mant[22:0]};
    end
  end

  // One Newton-Raphson step: r = r0 + r0*(1 - r0*d).
  fsig_fma u_g  (.clk(clk), .en(adv), .a(r0_r ^ fsig_pkg::F_SIGN), .b(d_d_r[D_LEN-1]),
                 .c(fsig_pkg::F_ONE), .r(gg));
  fsig_fma u_r  (.clk(clk), .en(adv), .a(gg), .b(r0_d_r[T_G-T_R0-1]),
                 .c(r0_d_r[T_G-T_R0-1]), .r(rr));

  // f = exp(z) / (1 + exp(z)), forced to zero below the cutoff.
  fsig_fma u_f  (.clk(clk), .en(adv), .a(e_d_r[E_LEN-1]), .b(rr),
                 .c(fsig_pkg::F_NEG_ZERO), .r(ff));

  assign f_cut = (in_pipe_r[T_F].x_bits[30:0] > fsig_pkg::CUTOFF_ABS) ? 32'd0 : ff;

  // 1 - f for non-negative inputs.
  fsig_fma u_y  (.clk(clk), .en(adv), .a(fsig_pkg::F_ONE), .b(fsig_pkg::F_ONE),
                 .c(f_cut ^ fsig_pkg::F_SIGN), .r(y1));

  // Final selection: NaN passes through, the sign of x picks f or 1 - f.
  logic [31:0] x_fin;
  logic [31:0] y_fin;

  always_comb begin
    x_fin = in_pipe_r[T_Y].x_bits;
    if (x_fin[30:0] > fsig_pkg::INF_ABS) begin
      y_fin = x_fin | fsig_pkg::F_NAN_SET;
    end else if (x_fin[31]) begin
      y_fin = f_d_r[F_LEN-1];
    end else begin
      y_fin = y1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[T_Y];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.y_bits            <= y_fin;
      out_data_r.end_of_vector_out <= in_pipe_r[T_Y].end_of_vector;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result whose exponent is not all ones is a non-negative value no greater than one.
  `FSIG_ASSERT_IMPL(a_range, out_valid_r && (out_data_r.y_bits[30:23] != 8'hFF), !out_data_r.y_bits[31] && (out_data_r.y_bits[30:0] <= 31'h3F80_0000), "sigmoid result out of range")
  // A NaN result is always negative and quiet.
  `FSIG_ASSERT_IMPL(a_nan, out_valid_r && (out_data_r.y_bits[30:0] > fsig_pkg::INF_ABS), out_data_r.y_bits[31] && out_data_r.y_bits[22], "NaN result lacks sign or quiet bit")
  // An accepted word enters the first stage.
  `FSIG_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld_r[0], "accepted word lost at entry")

endmodule
